>>> sv/srt_pkg.sv
// Shared types, codes and sizes of the sorted region table.
package srt_pkg;

   // table size and field widths
   localparam int MAX_REGIONS = 16;
   localparam int INDEX_W     = $clog2(MAX_REGIONS);
   localparam int COUNT_W     = $clog2(MAX_REGIONS + 1);
   localparam int ADDR_W      = 48;
   localparam int PERM_W      = 8;
   localparam int RTYPE_W     = 4;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 112;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   // operation codes carried in the request tuser
   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // configuration register indexes
   localparam logic [1:0] REG_LOWEST_ADDRESS = 2'd0;
   localparam logic [1:0] REG_ADDRESS_LIMIT  = 2'd1;
   localparam logic [1:0] REG_TYPE_MIN       = 2'd2;
   localparam logic [1:0] REG_TYPE_MAX       = 2'd3;

   // configuration reset values
   localparam logic [ADDR_W-1:0]  LOWEST_ADDRESS_RESET = 48'd4096;
   localparam logic [ADDR_W-1:0]  ADDRESS_LIMIT_RESET  = 48'hFFFF_FFFF_FFFF;
   localparam logic [RTYPE_W-1:0] TYPE_MIN_RESET       = 4'd0;
   localparam logic [RTYPE_W-1:0] TYPE_MAX_RESET       = 4'd15;

   // one stored region
   typedef struct packed {
      logic [RTYPE_W-1:0] rtype;
      logic [PERM_W-1:0]  permission;
      logic [ADDR_W-1:0]  length;
      logic [ADDR_W-1:0]  start;
   } region_entry_type;

   // compare results a cell registers when a request word is taken
   typedef struct packed {
      logic contains;
      logic above;
      logic exact;
      logic overlap;
   } cell_flag_type;

   // what a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;

   // configuration values seen by the core
   typedef struct packed {
      logic [ADDR_W-1:0]  lowest_address;
      logic [ADDR_W-1:0]  address_limit;
      logic [RTYPE_W-1:0] type_min;
      logic [RTYPE_W-1:0] type_max;
   } csr_cfg_type;

   // control sequence of the core
   typedef enum logic {
      FSM_IDLE,
      FSM_DECIDE
   } fsm_state_type;

endpackage

>>> sv/srt_cell.sv
// One table cell: holds a region, compares it to a request, shifts with its neighbors.
module srt_cell (
   input  logic                         clock,
   input  logic                         capture,
   input  logic                         valid,
   input  logic [srt_pkg::ADDR_W-1:0]   lookup_address,
   input  logic [srt_pkg::ADDR_W-1:0]   lookup_length,
   input  srt_pkg::cell_op_type         op,
   input  srt_pkg::region_entry_type    new_entry,
   input  srt_pkg::region_entry_type    left_entry,
   input  srt_pkg::region_entry_type    right_entry,
   output srt_pkg::region_entry_type    entry,
   output srt_pkg::cell_flag_type       flags
);
   import srt_pkg::*;

   region_entry_type    entry_ff, entry_in;
   cell_flag_type       flags_ff, flags_in;
   logic [ADDR_W:0]     entry_end;
   logic [ADDR_W:0]     lookup_end;

   // compare the stored region against the incoming word
   always_comb begin
      entry_end  = {1'b0, entry_ff.start} + {1'b0, entry_ff.length};
      lookup_end = {1'b0, lookup_address} + {1'b0, lookup_length};
      flags_in.contains = valid && (lookup_address >= entry_ff.start) &&
                          ({1'b0, lookup_address} < entry_end);
      flags_in.above    = valid && (entry_ff.start > lookup_address);
      flags_in.exact    = (entry_ff.start == lookup_address) &&
                          (entry_ff.length == lookup_length);
      flags_in.overlap  = valid && !((lookup_end <= {1'b0, entry_ff.start}) ||
                                     (entry_end <= {1'b0, lookup_address}));
   end

   // select the next content of the cell
   always_comb begin
      case (op)
         CELL_HOLD:       entry_in = entry_ff;
         CELL_LOAD:       entry_in = new_entry;
         CELL_FROM_LEFT:  entry_in = left_entry;
         CELL_FROM_RIGHT: entry_in = right_entry;
         default:         entry_in = entry_ff;
      endcase
   end

   // hold the region and the compare flags
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (capture) begin
         flags_ff <= flags_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

>>> sv/srt_csr.sv
// Configuration registers of the sorted region table behind an APB-style port.
module srt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [srt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [srt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [srt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output srt_pkg::csr_cfg_type             cfg
);
   import srt_pkg::*;

   csr_cfg_type  cfg_ff, cfg_in;
   logic [1:0]   reg_index;
   logic         write_word;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign write_word = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // update the addressed register on a completed write
   always_comb begin
      cfg_in = cfg_ff;
      if (write_word) begin
         case (reg_index)
            REG_LOWEST_ADDRESS: cfg_in.lowest_address = csr_pwdata[ADDR_W-1:0];
            REG_ADDRESS_LIMIT:  cfg_in.address_limit  = csr_pwdata[ADDR_W-1:0];
            REG_TYPE_MIN:       cfg_in.type_min       = csr_pwdata[RTYPE_W-1:0];
            REG_TYPE_MAX:       cfg_in.type_max       = csr_pwdata[RTYPE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowest_address <= LOWEST_ADDRESS_RESET;
         cfg_ff.address_limit  <= ADDRESS_LIMIT_RESET;
         cfg_ff.type_min       <= TYPE_MIN_RESET;
         cfg_ff.type_max       <= TYPE_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // return the addressed register
   always_comb begin
      case (reg_index)
         REG_LOWEST_ADDRESS: csr_prdata = CSR_DATA_W'(cfg_ff.lowest_address);
         REG_ADDRESS_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.address_limit);
         REG_TYPE_MIN:       csr_prdata = CSR_DATA_W'(cfg_ff.type_min);
         REG_TYPE_MAX:       csr_prdata = CSR_DATA_W'(cfg_ff.type_max);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/sorted_region_table_core.sv
// Top level of the sorted region table: cell row, decision step and result register.
//
// Usage: a request word on req_* carries an operation in req_tuser (find, insert,
// remove) and a region in req_tdata. Each request yields exactly one result word
// on rsp_*: a status, a hit flag and, for a find that hits, the found region.
// Regions are kept in a row of 16 cells sorted by start address.
// Timing: a request is taken at an edge while the core is idle. At that edge every
// cell registers its compare flags against the request. In the decision step the
// core picks the result from the flags, shifts the cell row for an insert or a
// remove and loads the result register, which raises rsp_tvalid. The core takes
// no new request until the decision step is done, as the compare-then-shift
// sequence over the cell row demands.
// Stall: while an earlier result waits in the result register, the core still
// takes a new request; its decision step waits until the result is taken.
// Reset (synchronous, active high) empties the table, restores the configuration
// registers and drops any pending result. The table contents themselves are not
// cleared: only cells below the region count are ever consulted.
// Configuration is written over csr_* while the core is idle: a rule for the user, not enforced by the core.
module sorted_region_table_core (
   input  logic                             clock,
   input  logic                             reset,
   // request: address[47:0], region_length[95:48], permission[103:96],
   // region_type[107:104], zero fill[111:108]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request tuser: kind[1:0]
   input  logic [srt_pkg::KIND_W-1:0]       req_tuser,
   // result: status[2:0], hit[3], found_start[51:4], found_length[99:52],
   // found_permission[107:100], found_type[111:108]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [srt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [srt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [srt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import srt_pkg::*;

   csr_cfg_type                   cfg;
   fsm_state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [KIND_W-1:0]             kind_ff;
   region_entry_type              new_entry_ff;
   logic                          invalid_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;

   region_entry_type              req_entry;
   logic                          req_word;
   logic                          invalid_in;
   logic [ADDR_W:0]               req_end;

   region_entry_type              cell_entry [MAX_REGIONS];
   cell_flag_type                 cell_flags [MAX_REGIONS];
   cell_op_type                   cell_op    [MAX_REGIONS];
   logic [MAX_REGIONS-1:0]        cell_valid;

   logic [MAX_REGIONS-1:0]        contains_vec, above_vec, exact_vec, overlap_vec;
   logic [MAX_REGIONS-1:0]        first_hit, del_mask, del_move;
   logic [MAX_REGIONS-1:0]        ins_mask, ins_prev, first_ins;
   logic                          hit_any, overlap_any, table_full, remove_ok;
   logic                          commit, do_insert, do_remove;
   logic [STATUS_W-1:0]           status;
   region_entry_type              found;

   // configuration registers
   srt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the request word
   assign req_entry.start      = req_tdata[47:0];
   assign req_entry.length     = req_tdata[95:48];
   assign req_entry.permission = req_tdata[103:96];
   assign req_entry.rtype      = req_tdata[107:104];
   assign req_word             = req_tvalid && req_tready;
   assign req_tready           = (state_ff == FSM_IDLE);

   // check bounds and type of the incoming word
   always_comb begin
      req_end    = {1'b0, req_entry.start} + {1'b0, req_entry.length};
      invalid_in = (req_entry.start < cfg.lowest_address) ||
                   (req_end >= {1'b0, cfg.address_limit}) ||
                   (req_entry.rtype < cfg.type_min) ||
                   (req_entry.rtype > cfg.type_max);
   end

   // row of cells
   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      region_entry_type left_entry;
      region_entry_type right_entry;

      assign cell_valid[i] = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_entry = new_entry_ff;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
      end

      if (i == MAX_REGIONS - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      srt_cell u_cell (
         .clock          (clock),
         .capture        (req_word),
         .valid          (cell_valid[i]),
         .lookup_address (req_entry.start),
         .lookup_length  (req_entry.length),
         .op             (cell_op[i]),
         .new_entry      (new_entry_ff),
         .left_entry     (left_entry),
         .right_entry    (right_entry),
         .entry          (cell_entry[i]),
         .flags          (cell_flags[i])
      );

      assign contains_vec[i] = cell_flags[i].contains;
      assign above_vec[i]    = cell_flags[i].above;
      assign exact_vec[i]    = cell_flags[i].exact;
      assign overlap_vec[i]  = cell_flags[i].overlap;
   end

   // locate the first containing cell and the shift ranges
   always_comb begin
      hit_any     = |contains_vec;
      first_hit   = contains_vec & (~contains_vec + MAX_REGIONS'(1));
      del_mask    = hit_any ? ~(first_hit - MAX_REGIONS'(1)) : '0;
      del_move    = del_mask;
      del_move[MAX_REGIONS-1] = 1'b0;
      remove_ok   = hit_any && |(first_hit & exact_vec);
      overlap_any = |overlap_vec;
      table_full  = (count_ff == COUNT_W'(MAX_REGIONS));
      ins_mask    = above_vec | ~cell_valid;
      ins_prev    = {ins_mask[MAX_REGIONS-2:0], 1'b0};
      first_ins   = ins_mask & ~ins_prev;
   end

   // mux out the found region
   always_comb begin
      found = '0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         found = found | ({$bits(region_entry_type){first_hit[i]}} & cell_entry[i]);
      end
   end

   // result status per operation
   always_comb begin
      case (kind_ff)
         KIND_FIND:   status = hit_any ? ST_OK : ST_NOTFOUND;
         KIND_INSERT: begin
            if (invalid_ff) begin
               status = ST_INVALID;
            end else if (overlap_any) begin
               status = ST_OVERLAP;
            end else if (table_full) begin
               status = ST_FULL;
            end else begin
               status = ST_OK;
            end
         end
         KIND_REMOVE: status = remove_ok ? ST_OK : ST_NOTFOUND;
         default:     status = ST_INVALID;
      endcase
   end

   // sequence the decision step and drive the cell row
   always_comb begin
      state_in     = state_ff;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_word) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               commit       = 1'b1;
               state_in     = FSM_IDLE;
               rsp_valid_in = 1'b1;
               if ((kind_ff == KIND_FIND) && hit_any) begin
                  rsp_data_in = {found.rtype, found.permission, found.length,
                                 found.start, 1'b1, status};
               end else begin
                  rsp_data_in = {(RSP_DATA_W - STATUS_W - 1)'(0), 1'b0, status};
               end
            end
         end
         default: state_in = FSM_IDLE;
      endcase
      do_insert = commit && (kind_ff == KIND_INSERT) && (status == ST_OK);
      do_remove = commit && (kind_ff == KIND_REMOVE) && (status == ST_OK);
      count_in  = count_ff;
      if (do_insert) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - COUNT_W'(1);
      end
      for (int i = 0; i < MAX_REGIONS; i++) begin
         cell_op[i] = CELL_HOLD;
         if (do_insert && first_ins[i]) begin
            cell_op[i] = CELL_LOAD;
         end else if (do_insert && ins_mask[i]) begin
            cell_op[i] = CELL_FROM_LEFT;
         end else if (do_remove && del_move[i]) begin
            cell_op[i] = CELL_FROM_RIGHT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request and the result word
   always_ff @(posedge clock) begin
      if (req_word) begin
         kind_ff      <= req_tuser;
         new_entry_ff <= req_entry;
         invalid_ff   <= invalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // region count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_REGIONS))
      else $error("region count beyond table size");

   // a taken request always moves to the decision step
   a_accept_decide: assert property (@(posedge clock) disable iff (reset)
      req_word |=> (state_ff == FSM_DECIDE) && !req_tready)
      else $error("request taken without decision step");

   // the count moves by at most one per step
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff)) ||
                         (count_ff == $past(count_ff) + COUNT_W'(1)) ||
                         (count_ff == $past(count_ff) - COUNT_W'(1))))
      else $error("region count jumped");

   // the table changes only in a committed decision step
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(commit)) |-> $stable(count_ff))
      else $error("region count changed outside a decision step");

   // a hit always reports success
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[STATUS_W]) |-> (rsp_data_ff[STATUS_W-1:0] == ST_OK))
      else $error("hit flagged with failing status");

endmodule
